[src/sapq_pkg.sv]
// sapq_pkg: shared types and constants for the sorted array priority queue
// depends on nothing; used by the core and the checker
package sapq_pkg;

   localparam int DEPTH         = 16;
   localparam int TAG_BITS      = 16;
   localparam int PRIO_BITS     = 32;
   localparam int TAG_PORT_BITS = 16;
   localparam int IDX_BITS      = $clog2(DEPTH);
   localparam int CNT_BITS      = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      MODE_ENQ = 2'd0,
      MODE_DEQ = 2'd1,
      MODE_CLR = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_POP,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic signed [PRIO_BITS-1:0] prio;
      logic [TAG_BITS-1:0]         tag;
   } entry_type;

endpackage

[src/sapq_slot_ram.sv]
// sapq_slot_ram: one write port, one read port memory with registered read data
// generic; no package dependency
module sapq_slot_ram #(
   parameter int DATA_BITS = 48,
   parameter int ADDR_BITS = 4
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [(1 << ADDR_BITS)];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/sorted_array_priority_queue_core.sv]
// sorted_array_priority_queue_core: enqueue walks from the back with one shared compare
// enqueue goes IDLE, SCAN (moving k held entries, up to DEPTH - 1), FINISH; dequeue goes
// IDLE, POP, FINISH; clear, refused and no-op beats IDLE, FINISH; next beat taken in IDLE
// the insertion walk is bound by the single read and write port of the slot memory
// reset (synchronous, active high) empties the queue; slot contents are not cleared
// depends on sapq_pkg and sapq_slot_ram
module sorted_array_priority_queue_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_mode,
   input  logic signed [sapq_pkg::PRIO_BITS-1:0] req_in_priority,
   input  logic [sapq_pkg::TAG_PORT_BITS-1:0]    req_in_tag,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [1:0]                            rsp_status,
   output logic signed [sapq_pkg::PRIO_BITS-1:0] rsp_out_priority,
   output logic [sapq_pkg::TAG_PORT_BITS-1:0]    rsp_out_tag,
   output logic [sapq_pkg::CNT_BITS-1:0]         rsp_entry_count,
   output logic signed [sapq_pkg::PRIO_BITS-1:0] rsp_front_priority,
   output logic [sapq_pkg::TAG_PORT_BITS-1:0]    rsp_front_tag
);

   // sequencer state
   sapq_pkg::state_type              state_ff, state_in;
   logic [sapq_pkg::CNT_BITS-1:0]    count_ff, count_in;   // entries held
   logic [sapq_pkg::CNT_BITS-1:0]    idx_ff, idx_in;       // hole being filled
   sapq_pkg::entry_type              new_ff, new_in;       // entry being inserted
   sapq_pkg::entry_type              front_ff, front_in;   // copy of slot count-1
   sapq_pkg::entry_type              deq_ff, deq_in;       // popped entry or zero
   sapq_pkg::status_type             status_ff, status_in;

   // response register
   logic                             rsp_valid_ff, rsp_valid_in;
   sapq_pkg::status_type             rsp_status_ff, rsp_status_in;
   sapq_pkg::entry_type              rsp_deq_ff, rsp_deq_in;
   sapq_pkg::entry_type              rsp_front_ff, rsp_front_in;
   logic [sapq_pkg::CNT_BITS-1:0]    rsp_count_ff, rsp_count_in;

   // slot memory ports
   logic                             wr_en;
   logic [sapq_pkg::IDX_BITS-1:0]    wr_addr;
   sapq_pkg::entry_type              wr_data;
   logic [sapq_pkg::CNT_BITS-1:0]    rd_sel;
   logic [sapq_pkg::IDX_BITS-1:0]    rd_addr;
   logic [$bits(sapq_pkg::entry_type)-1:0] rd_raw;
   sapq_pkg::entry_type              rd_entry;

   logic                             req_accept;
   logic                             rsp_free;
   logic                             moves_back;   // shared compare: slot below new entry

   sapq_slot_ram #(
      .DATA_BITS ($bits(sapq_pkg::entry_type)),
      .ADDR_BITS (sapq_pkg::IDX_BITS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_entry   = rd_raw;
   assign req_stall  = (state_ff != sapq_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // the slot just under the next hole is fetched every cycle, so it is ready
   // in the next cycle when the walk looks at it
   assign rd_sel  = idx_in - sapq_pkg::CNT_BITS'(1);
   assign rd_addr = rd_sel[sapq_pkg::IDX_BITS-1:0];

   // the one compare: does the stored entry rank below the new one
   assign moves_back = ($signed(rd_entry.prio) < $signed(new_ff.prio));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sapq_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      new_ff        <= new_in;
      front_ff      <= front_in;
      deq_ff        <= deq_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_deq_ff    <= rsp_deq_in;
      rsp_front_ff  <= rsp_front_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      new_in        = new_ff;
      front_in      = front_ff;
      deq_in        = deq_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_deq_in    = rsp_deq_ff;
      rsp_front_in  = rsp_front_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[sapq_pkg::IDX_BITS-1:0];
      wr_data       = new_ff;

      unique case (state_ff)
         sapq_pkg::ST_IDLE: begin
            if (req_accept) begin
               status_in = sapq_pkg::STAT_OK;
               deq_in    = '0;
               state_in  = sapq_pkg::ST_FINISH;
               unique case (req_mode)
                  sapq_pkg::MODE_ENQ: begin
                     if (count_ff == sapq_pkg::CNT_BITS'(sapq_pkg::DEPTH)) begin
                        status_in = sapq_pkg::STAT_FULL;
                     end else begin
                        new_in.prio = req_in_priority;
                        new_in.tag  = sapq_pkg::TAG_BITS'(req_in_tag);
                        idx_in      = count_ff;
                        state_in    = sapq_pkg::ST_SCAN;
                     end
                  end
                  sapq_pkg::MODE_DEQ: begin
                     if (count_ff == '0) begin
                        status_in = sapq_pkg::STAT_EMPTY;
                     end else begin
                        // the front copy is the popped entry; fetch the new front
                        deq_in   = front_ff;
                        count_in = count_ff - sapq_pkg::CNT_BITS'(1);
                        idx_in   = count_ff - sapq_pkg::CNT_BITS'(1);
                        state_in = sapq_pkg::ST_POP;
                     end
                  end
                  sapq_pkg::MODE_CLR: begin
                     count_in = '0;
                  end
                  default: begin
                     // unused code: report only
                  end
               endcase
            end
         end

         sapq_pkg::ST_SCAN: begin
            wr_en = 1'b1;
            if ((idx_ff == '0) || !moves_back) begin
               // hole found: drop the new entry in
               wr_data  = new_ff;
               count_in = count_ff + sapq_pkg::CNT_BITS'(1);
               if (idx_ff == count_ff) begin
                  front_in = new_ff;
               end
               state_in = sapq_pkg::ST_FINISH;
            end else begin
               // move the lower-ranked entry up one slot and keep walking
               wr_data = rd_entry;
               idx_in  = idx_ff - sapq_pkg::CNT_BITS'(1);
            end
         end

         sapq_pkg::ST_POP: begin
            front_in = rd_entry;
            state_in = sapq_pkg::ST_FINISH;
         end

         sapq_pkg::ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_deq_in    = deq_ff;
               rsp_count_in  = count_ff;
               rsp_front_in  = (count_ff == '0) ? '0 : front_ff;
               state_in      = sapq_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = sapq_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_out_priority   = rsp_deq_ff.prio;
   assign rsp_out_tag        = sapq_pkg::TAG_PORT_BITS'(rsp_deq_ff.tag);
   assign rsp_entry_count    = rsp_count_ff;
   assign rsp_front_priority = rsp_front_ff.prio;
   assign rsp_front_tag      = sapq_pkg::TAG_PORT_BITS'(rsp_front_ff.tag);

endmodule

[src/sapq_checker.sv]
// sapq_checker: port-level checks for the sorted array priority queue core
// depends on sapq_pkg; bound to sorted_array_priority_queue_core below
module sapq_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic [1:0]                            rsp_status,
   input logic signed [sapq_pkg::PRIO_BITS-1:0] rsp_out_priority,
   input logic [sapq_pkg::TAG_PORT_BITS-1:0]    rsp_out_tag,
   input logic [sapq_pkg::CNT_BITS-1:0]         rsp_entry_count,
   input logic signed [sapq_pkg::PRIO_BITS-1:0] rsp_front_priority,
   input logic [sapq_pkg::TAG_PORT_BITS-1:0]    rsp_front_tag
);

   // a beat held back stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // one request at a time: a taken beat closes the input
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while one is in progress");

   a_empty_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == sapq_pkg::STAT_EMPTY |->
         rsp_entry_count == '0 && rsp_out_priority == '0 && rsp_out_tag == '0)
      else $error("empty status with entries or popped data");

   a_full_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == sapq_pkg::STAT_FULL |->
         rsp_entry_count == sapq_pkg::CNT_BITS'(sapq_pkg::DEPTH))
      else $error("full status on a queue that is not full");

   a_empty_front: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_count == '0 |->
         rsp_front_priority == '0 && rsp_front_tag == '0)
      else $error("front shown on an empty queue");

endmodule

bind sorted_array_priority_queue_core sapq_checker u_sapq_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_status         (rsp_status),
   .rsp_out_priority   (rsp_out_priority),
   .rsp_out_tag        (rsp_out_tag),
   .rsp_entry_count    (rsp_entry_count),
   .rsp_front_priority (rsp_front_priority),
   .rsp_front_tag      (rsp_front_tag)
);
